@@ rtl/core/tcpopt_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpopt_pkg
// Shared types, option codes and helpers for the TCP option parser/builder.
// ----------------------------------------------------------------------------
package tcpopt_pkg;

    // Size of the TCP options region; larger bytes_left values saturate to it
    localparam int unsigned MAX_OPTION_BYTES = 40;

    localparam int unsigned BYTES_LEFT_W = 6;
    localparam int unsigned REPLY_MAX    = 8;
    localparam int unsigned REPLY_IDX_W  = $clog2(REPLY_MAX);
    localparam int unsigned REPLY_CNT_W  = $clog2(REPLY_MAX + 1);
    localparam int unsigned ADDR_W       = 3;

    // Option kinds
    localparam logic [7:0] KIND_EOL     = 8'd0;
    localparam logic [7:0] KIND_NOP     = 8'd1;
    localparam logic [7:0] KIND_MSS     = 8'd2;
    localparam logic [7:0] KIND_WSCALE  = 8'd3;
    localparam logic [7:0] KIND_SACK_OK = 8'd4;

    // Option lengths
    localparam logic [7:0] LEN_MSS      = 8'd4;
    localparam logic [7:0] LEN_WSCALE   = 8'd3;
    localparam logic [7:0] LEN_SACK_OK  = 8'd2;
    localparam logic [7:0] LEN_MIN      = 8'd2;

    localparam logic [3:0]  PEER_SCALE_DEFAULT = 4'd7;
    localparam logic [15:0] LOCAL_MSS_RESET    = 16'd1460;
    localparam logic [3:0]  LOCAL_SHIFT_RESET  = 4'd0;

    // Register map: register index = paddr[2]
    typedef enum logic {
        REG_LOCAL_MSS   = 1'b0,
        REG_LOCAL_SHIFT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_KIND   = 3'd0,
        PH_LEN    = 3'd1,
        PH_MSS_HI = 3'd2,
        PH_MSS_LO = 3'd3,
        PH_SHIFT  = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    typedef enum logic {
        RES_SUMMARY = 1'b0,
        RES_BYTE    = 1'b1
    } res_kind_t;

    typedef struct packed {
        logic        mss_seen;
        logic [15:0] mss;
        logic        scale_seen;
        logic [7:0]  shift;
        logic        sack_seen;
    } peer_rec_t;

    typedef logic [REPLY_MAX-1:0][7:0] reply_bytes_t;

    typedef struct packed {
        reply_bytes_t             bytes;
        logic [REPLY_CNT_W-1:0]   count;
    } reply_t;

    // Padded reply length: MSS 4, scale 3, EOL 1, rounded up to 4
    function automatic logic [3:0] reply_size_f(input logic mss_seen,
                                                input logic scale_seen);
        logic [3:0] raw;
        raw = 4'd1 + (mss_seen ? 4'd4 : 4'd0) + (scale_seen ? 4'd3 : 4'd0);
        return (raw + 4'd3) & 4'b1100;
    endfunction

endpackage

@@ rtl/core/tcp_option_parse_build.sv @@
// ----------------------------------------------------------------------------
// tcp_option_parse_build
// TCP header option parser with reply option builder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one request per accepted cycle. With
// action 0 a request carries one received option byte and the count of
// option bytes left in the region; with action 1 it asks for the reply
// option bytes of a header with the given SYN and ACK flags.
// Output channel (out_valid/out_stall): a parse summary after each region
// end, or the reply bytes of a build request, one result per cycle unless
// the receiver stalls. The first result of a request is valid the cycle
// after it is accepted. A parse byte that does not end its region has no
// result and is taken every cycle even while the result register is full.
// A request with results is taken when the result register is empty or its
// last result is being taken in that same cycle, so summaries also stream
// at one per cycle unless the receiver stalls. A build request holds the
// result register until its 4 or 8 reply bytes are out; that paces builds.
// Reset clears the parse state and the peer record, loads local_mss with
// 1460 and the local shift with 0, and empties the result register. While
// the receiver stalls, the pending result holds and requests with results
// stall on the input side.
// Configuration: APB, local_mss at byte 0, local_shift_initial at byte 4.
// ----------------------------------------------------------------------------
module tcp_option_parse_build
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [7:0]                            opt_byte,
    input  logic [tcpopt_pkg::BYTES_LEFT_W-1:0]   bytes_left,
    input  logic                                  syn_flag,
    input  logic                                  ack_flag,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  result_kind,
    output logic [7:0]                            out_byte,
    output logic                                  out_last,
    output logic                                  peer_mss_seen,
    output logic [15:0]                           peer_mss,
    output logic                                  peer_scale_seen,
    output logic [7:0]                            peer_shift,
    output logic                                  peer_sack_seen,
    output logic [3:0]                            reply_size,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tcpopt_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import tcpopt_pkg::*;

    logic [15:0]  local_mss_reg, local_mss_next;
    logic [3:0]   shift_init_reg, shift_init_next;
    logic         cfg_wr;
    cfg_reg_t     cfg_sel;

    logic         in_accept;
    logic         has_result;
    logic         region_end;
    logic         out_done;

    peer_rec_t    peer_now;
    peer_rec_t    peer_next;
    logic [3:0]   local_shift;
    reply_t       reply;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        local_mss_next  = local_mss_reg;
        shift_init_next = shift_init_reg;
        if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_LOCAL_MSS:   local_mss_next  = pwdata[15:0];
                REG_LOCAL_SHIFT: shift_init_next = pwdata[3:0];
                default:         local_mss_next  = local_mss_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mss_reg  <= LOCAL_MSS_RESET;
            shift_init_reg <= LOCAL_SHIFT_RESET;
        end
        else
        begin
            local_mss_reg  <= local_mss_next;
            shift_init_reg <= shift_init_next;
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_LOCAL_MSS:   prdata = {16'd0, local_mss_reg};
            REG_LOCAL_SHIFT: prdata = {28'd0, shift_init_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input handshake: hold only requests that produce results while the
    // result register is still draining.
    // ------------------------------------------------------------------
    assign region_end = (bytes_left <= BYTES_LEFT_W'(1));
    assign has_result = action ? (reply.count != '0) : region_end;
    assign in_stall   = out_valid && !out_done && has_result;
    assign in_accept  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Parse state machine and peer record
    // ------------------------------------------------------------------
    tcpopt_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (in_accept && !action),
        .opt_byte      (opt_byte),
        .bytes_left    (bytes_left),
        .cfg_shift_wr  (cfg_wr && (cfg_sel == REG_LOCAL_SHIFT)),
        .cfg_shift_val (pwdata[3:0]),
        .peer_now      (peer_now),
        .peer_next     (peer_next),
        .local_shift   (local_shift)
    );

    // ------------------------------------------------------------------
    // Reply byte list from the current peer record and own settings
    // ------------------------------------------------------------------
    tcpopt_reply_gen u_reply_gen
    (
        .syn_flag    (syn_flag),
        .ack_flag    (ack_flag),
        .mss_seen    (peer_now.mss_seen),
        .scale_seen  (peer_now.scale_seen),
        .local_mss   (local_mss_reg),
        .local_shift (local_shift),
        .reply       (reply)
    );

    // ------------------------------------------------------------------
    // Result register and burst drain
    // ------------------------------------------------------------------
    tcpopt_out_queue u_out_queue
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (in_accept && has_result),
        .load_reply      (action),
        .reply           (reply),
        .summary         (peer_next),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .done            (out_done),
        .result_kind     (result_kind),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .peer_mss_seen   (peer_mss_seen),
        .peer_mss        (peer_mss),
        .peer_scale_seen (peer_scale_seen),
        .peer_shift      (peer_shift),
        .peer_sack_seen  (peer_sack_seen),
        .reply_size      (reply_size)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A region end always leaves a summary in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !action && region_end) |=> (out_valid && !result_kind))
    else $error("region end did not produce a summary");

    // A SYN without ACK always opens its reply with the MSS option.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && action && syn_flag && !ack_flag)
        |=> (out_valid && result_kind && (out_byte == KIND_MSS)))
    else $error("SYN reply does not start with MSS");

    // A summary is a single result with an aligned reply size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_kind)
        |-> (out_last && ((reply_size == 4'd4) || (reply_size == 4'd8))))
    else $error("malformed parse summary");

    // A reply burst ends with EOL.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind && out_last) |-> (out_byte == KIND_EOL))
    else $error("reply burst not closed by EOL");

endmodule

@@ rtl/core/tcpopt_parser.sv @@
// ----------------------------------------------------------------------------
// tcpopt_parser
// Option byte state machine and peer record; one byte per step.
// ----------------------------------------------------------------------------
module tcpopt_parser
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step_en,
    input  logic [7:0]                            opt_byte,
    input  logic [tcpopt_pkg::BYTES_LEFT_W-1:0]   bytes_left,
    input  logic                                  cfg_shift_wr,
    input  logic [3:0]                            cfg_shift_val,
    output tcpopt_pkg::peer_rec_t                 peer_now,
    output tcpopt_pkg::peer_rec_t                 peer_next,
    output logic [3:0]                            local_shift
);
    import tcpopt_pkg::*;

    localparam logic [BYTES_LEFT_W-1:0] MAX_LEFT = BYTES_LEFT_W'(MAX_OPTION_BYTES);

    phase_t                  phase_reg, phase_next;
    logic [7:0]              kind_reg, kind_next;
    logic [7:0]              skip_reg, skip_next;
    logic [BYTES_LEFT_W-1:0] kleft_reg, kleft_next;
    logic [7:0]              mss_hi_reg, mss_hi_next;
    logic                    stopped_reg, stopped_next;
    peer_rec_t               peer_reg, peer_nx;
    logic [3:0]              lshift_reg, lshift_next;
    logic [BYTES_LEFT_W-1:0] left_sat;
    logic                    region_end;
    logic                    scale_hit;

    assign left_sat   = (bytes_left > MAX_LEFT) ? MAX_LEFT : bytes_left;
    assign region_end = (left_sat <= BYTES_LEFT_W'(1));

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        skip_next    = skip_reg;
        kleft_next   = kleft_reg;
        mss_hi_next  = mss_hi_reg;
        stopped_next = stopped_reg;
        peer_nx      = peer_reg;
        scale_hit    = 1'b0;

        if (!stopped_reg)
        begin
            unique case (phase_reg)
                PH_KIND:
                begin
                    if (opt_byte == KIND_EOL)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (opt_byte != KIND_NOP)
                    begin
                        kind_next  = opt_byte;
                        kleft_next = left_sat;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (opt_byte > {2'b00, kleft_reg})
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (kind_reg == KIND_MSS)
                    begin
                        if (opt_byte == LEN_MSS) phase_next = PH_MSS_HI;
                        else stopped_next = 1'b1;
                    end
                    else if (kind_reg == KIND_WSCALE)
                    begin
                        if (opt_byte == LEN_WSCALE) phase_next = PH_SHIFT;
                        else stopped_next = 1'b1;
                    end
                    else if (kind_reg == KIND_SACK_OK)
                    begin
                        if (opt_byte == LEN_SACK_OK)
                        begin
                            peer_nx.sack_seen = 1'b1;
                            phase_next        = PH_KIND;
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                    else if (opt_byte < LEN_MIN)
                    begin
                        // unknown kind with length 0 or 1 cannot advance
                        stopped_next = 1'b1;
                    end
                    else if (opt_byte == LEN_MIN)
                    begin
                        phase_next = PH_KIND;
                    end
                    else
                    begin
                        skip_next  = opt_byte - LEN_MIN;
                        phase_next = PH_SKIP;
                    end
                end
                PH_MSS_HI:
                begin
                    mss_hi_next = opt_byte;
                    phase_next  = PH_MSS_LO;
                end
                PH_MSS_LO:
                begin
                    peer_nx.mss      = {mss_hi_reg, opt_byte};
                    peer_nx.mss_seen = 1'b1;
                    phase_next       = PH_KIND;
                end
                PH_SHIFT:
                begin
                    peer_nx.shift      = opt_byte;
                    peer_nx.scale_seen = 1'b1;
                    scale_hit          = 1'b1;
                    phase_next         = PH_KIND;
                end
                PH_SKIP:
                begin
                    if (skip_reg != 8'd0)
                        skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0)
                        phase_next = PH_KIND;
                end
                default:
                begin
                    phase_next = PH_KIND;
                end
            endcase
        end

        // rearm at the end of the region
        if (region_end)
        begin
            phase_next   = PH_KIND;
            stopped_next = 1'b0;
            skip_next    = 8'd0;
        end

        lshift_next = lshift_reg;
        if (step_en && scale_hit)
            lshift_next = PEER_SCALE_DEFAULT;
        else if (cfg_shift_wr && !peer_reg.scale_seen)
            lshift_next = cfg_shift_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_KIND;
            kind_reg    <= 8'd0;
            skip_reg    <= 8'd0;
            kleft_reg   <= '0;
            mss_hi_reg  <= 8'd0;
            stopped_reg <= 1'b0;
            peer_reg    <= '0;
            lshift_reg  <= LOCAL_SHIFT_RESET;
        end
        else
        begin
            lshift_reg <= lshift_next;
            if (step_en)
            begin
                phase_reg   <= phase_next;
                kind_reg    <= kind_next;
                skip_reg    <= skip_next;
                kleft_reg   <= kleft_next;
                mss_hi_reg  <= mss_hi_next;
                stopped_reg <= stopped_next;
                peer_reg    <= peer_nx;
            end
        end
    end

    assign peer_now    = peer_reg;
    assign peer_next   = peer_nx;
    assign local_shift = lshift_reg;

endmodule

@@ rtl/core/tcpopt_reply_gen.sv @@
// ----------------------------------------------------------------------------
// tcpopt_reply_gen
// Reply option byte list for a build request: MSS, window scale, padding.
// ----------------------------------------------------------------------------
module tcpopt_reply_gen
(
    input  logic                 syn_flag,
    input  logic                 ack_flag,
    input  logic                 mss_seen,
    input  logic                 scale_seen,
    input  logic [15:0]          local_mss,
    input  logic [3:0]           local_shift,
    output tcpopt_pkg::reply_t   reply
);
    import tcpopt_pkg::*;

    logic send_mss;
    logic send_scale;

    assign send_mss   = syn_flag && (mss_seen || !ack_flag);
    assign send_scale = syn_flag && (scale_seen || !ack_flag);

    always_comb
    begin
        reply.bytes = '0;
        reply.count = '0;
        priority if (send_mss)
        begin
            reply.bytes[0] = KIND_MSS;
            reply.bytes[1] = LEN_MSS;
            reply.bytes[2] = local_mss[15:8];
            reply.bytes[3] = local_mss[7:0];
            if (send_scale)
            begin
                reply.bytes[4] = KIND_WSCALE;
                reply.bytes[5] = LEN_WSCALE;
                reply.bytes[6] = {4'd0, local_shift};
            end
            else
            begin
                reply.bytes[4] = KIND_NOP;
                reply.bytes[5] = KIND_NOP;
                reply.bytes[6] = KIND_NOP;
            end
            reply.bytes[7] = KIND_EOL;
            reply.count    = REPLY_CNT_W'(8);
        end
        else if (send_scale)
        begin
            reply.bytes[0] = KIND_WSCALE;
            reply.bytes[1] = LEN_WSCALE;
            reply.bytes[2] = {4'd0, local_shift};
            reply.bytes[3] = KIND_EOL;
            reply.count    = REPLY_CNT_W'(4);
        end
        else
        begin
            reply.count = '0;
        end
    end

endmodule

@@ rtl/core/tcpopt_out_queue.sv @@
// ----------------------------------------------------------------------------
// tcpopt_out_queue
// Result register: holds one summary or one reply burst, drains a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module tcpopt_out_queue
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic                     load_reply,
    input  tcpopt_pkg::reply_t       reply,
    input  tcpopt_pkg::peer_rec_t    summary,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic                     done,
    output logic                     result_kind,
    output logic [7:0]               out_byte,
    output logic                     out_last,
    output logic                     peer_mss_seen,
    output logic [15:0]              peer_mss,
    output logic                     peer_scale_seen,
    output logic [7:0]               peer_shift,
    output logic                     peer_sack_seen,
    output logic [3:0]               reply_size
);
    import tcpopt_pkg::*;

    logic                    busy_reg, busy_next;
    logic [REPLY_IDX_W-1:0]  idx_reg, idx_next;
    res_kind_t               kind_reg;
    reply_bytes_t            bytes_reg;
    logic [REPLY_CNT_W-1:0]  cnt_reg;
    peer_rec_t               sum_reg;
    logic [3:0]              size_reg;
    logic                    is_byte;
    logic                    taken;

    assign is_byte  = (kind_reg == RES_BYTE);
    assign out_last = is_byte ? ({1'b0, idx_reg} == (cnt_reg - REPLY_CNT_W'(1))) : 1'b1;
    assign taken    = busy_reg && !out_stall;
    assign done     = taken && out_last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (taken)
        begin
            idx_next = idx_reg + REPLY_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= load_reply ? RES_BYTE : RES_SUMMARY;
            bytes_reg <= reply.bytes;
            cnt_reg   <= reply.count;
            sum_reg   <= summary;
            size_reg  <= reply_size_f(summary.mss_seen, summary.scale_seen);
        end
    end

    assign out_valid       = busy_reg;
    assign result_kind     = is_byte;
    assign out_byte        = is_byte ? bytes_reg[idx_reg] : 8'd0;
    assign peer_mss_seen   = is_byte ? 1'b0  : sum_reg.mss_seen;
    assign peer_mss        = is_byte ? 16'd0 : sum_reg.mss;
    assign peer_scale_seen = is_byte ? 1'b0  : sum_reg.scale_seen;
    assign peer_shift      = is_byte ? 8'd0  : sum_reg.shift;
    assign peer_sack_seen  = is_byte ? 1'b0  : sum_reg.sack_seen;
    assign reply_size      = is_byte ? 4'd0  : size_reg;

endmodule

@@ tb/tcp_option_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_option_checker
// Watches the request, result and APB channels of the TCP option block,
// predicts every result and compares it with what comes out.
// ----------------------------------------------------------------------------
module tcp_option_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  action,
    input  logic [7:0]                            opt_byte,
    input  logic [tcpopt_pkg::BYTES_LEFT_W-1:0]   bytes_left,
    input  logic                                  syn_flag,
    input  logic                                  ack_flag,

    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic                                  result_kind,
    input  logic [7:0]                            out_byte,
    input  logic                                  out_last,
    input  logic                                  peer_mss_seen,
    input  logic [15:0]                           peer_mss,
    input  logic                                  peer_scale_seen,
    input  logic [7:0]                            peer_shift,
    input  logic                                  peer_sack_seen,
    input  logic [3:0]                            reply_size,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic                                  pready,
    input  logic [tcpopt_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                           pwdata,

    output int                                    mismatches,
    output int                                    awaited,
    output int                                    results_checked
);
    import tcpopt_pkg::*;

    typedef struct packed {
        res_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        peer_rec_t   peer;
        logic [3:0]  rsize;
    } opt_result_t;

    opt_result_t awaited_q[$];

    // Shadow of the parser and the peer record
    phase_t      phase;
    logic [7:0]  kind;
    logic [7:0]  skip_left;
    logic [5:0]  kind_room;
    logic [7:0]  mss_hi;
    logic        halted;
    logic        mss_seen_r;
    logic [15:0] peer_mss_r;
    logic        scale_seen_r;
    logic [7:0]  peer_shift_r;
    logic        sack_seen_r;
    logic [7:0]  own_shift;
    logic [15:0] own_mss;

    function automatic string show(opt_result_t r);
        return $sformatf({"kind=%0d byte=%02h last=%0d mss=%0d:%04h ",
                          "scale=%0d:%02h sack=%0d size=%0d"},
                         r.kind, r.data, r.last, r.peer.mss_seen, r.peer.mss,
                         r.peer.scale_seen, r.peer.shift, r.peer.sack_seen, r.rsize);
    endfunction

    task automatic take_option_byte(input logic [7:0] b, input logic [5:0] raw_left);
        logic [5:0]  left;
        opt_result_t summary;
        left = (raw_left > 6'(MAX_OPTION_BYTES)) ? 6'(MAX_OPTION_BYTES) : raw_left;
        if (!halted)
        begin
            case (phase)
                PH_KIND:
                begin
                    if (b == KIND_EOL)
                        halted = 1'b1;
                    else if (b != KIND_NOP)
                    begin
                        kind      = b;
                        kind_room = left;
                        phase     = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (b > {2'b00, kind_room})
                        halted = 1'b1;
                    else if (kind == KIND_MSS)
                    begin
                        if (b == LEN_MSS)
                            phase = PH_MSS_HI;
                        else
                            halted = 1'b1;
                    end
                    else if (kind == KIND_WSCALE)
                    begin
                        if (b == LEN_WSCALE)
                            phase = PH_SHIFT;
                        else
                            halted = 1'b1;
                    end
                    else if (kind == KIND_SACK_OK)
                    begin
                        if (b == LEN_SACK_OK)
                        begin
                            sack_seen_r = 1'b1;
                            phase       = PH_KIND;
                        end
                        else
                            halted = 1'b1;
                    end
                    else if (b < LEN_MIN)
                        halted = 1'b1;
                    else if (b == LEN_MIN)
                        phase = PH_KIND;
                    else
                    begin
                        skip_left = b - LEN_MIN;
                        phase     = PH_SKIP;
                    end
                end
                PH_MSS_HI:
                begin
                    mss_hi = b;
                    phase  = PH_MSS_LO;
                end
                PH_MSS_LO:
                begin
                    peer_mss_r = {mss_hi, b};
                    mss_seen_r = 1'b1;
                    phase      = PH_KIND;
                end
                PH_SHIFT:
                begin
                    peer_shift_r = b;
                    scale_seen_r = 1'b1;
                    own_shift    = {4'd0, PEER_SCALE_DEFAULT};
                    phase        = PH_KIND;
                end
                PH_SKIP:
                begin
                    if (skip_left != 8'd0)
                        skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0)
                        phase = PH_KIND;
                end
                default:
                    phase = PH_KIND;
            endcase
        end
        if (left <= 6'd1)
        begin
            summary                 = '0;
            summary.kind            = RES_SUMMARY;
            summary.last            = 1'b1;
            summary.peer.mss_seen   = mss_seen_r;
            summary.peer.mss        = peer_mss_r;
            summary.peer.scale_seen = scale_seen_r;
            summary.peer.shift      = peer_shift_r;
            summary.peer.sack_seen  = sack_seen_r;
            // EOL alone or scale plus EOL pad to 4; MSS pushes it to 8
            summary.rsize           = mss_seen_r ? 4'd8 : 4'd4;
            awaited_q.push_back(summary);
            phase     = PH_KIND;
            halted    = 1'b0;
            skip_left = 8'd0;
        end
    endtask

    task automatic predict_reply_options(input logic syn, input logic ack);
        logic [7:0]  seq [REPLY_MAX];
        int          n;
        int          total;
        opt_result_t r;
        n = 0;
        if (syn)
        begin
            if (mss_seen_r || !ack)
            begin
                seq[0] = KIND_MSS;
                seq[1] = LEN_MSS;
                seq[2] = own_mss[15:8];
                seq[3] = own_mss[7:0];
                n      = 4;
            end
            if (scale_seen_r || !ack)
            begin
                seq[n]     = KIND_WSCALE;
                seq[n + 1] = LEN_WSCALE;
                seq[n + 2] = own_shift;
                n          = n + 3;
            end
        end
        if (n > 0)
        begin
            // pad with NOPs so that the closing EOL ends a 32-bit word
            total = (n + 4) & ~3;
            while (n < total - 1)
            begin
                seq[n] = KIND_NOP;
                n++;
            end
            seq[n] = KIND_EOL;
            n++;
            for (int k = 0; k < n; k++)
            begin
                r      = '0;
                r.kind = RES_BYTE;
                r.data = seq[k];
                r.last = (k == n - 1);
                awaited_q.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        opt_result_t seen;
        opt_result_t want;
        if (!rst_n)
        begin
            awaited_q.delete();
            phase           = PH_KIND;
            kind            = 8'd0;
            skip_left       = 8'd0;
            kind_room       = 6'd0;
            mss_hi          = 8'd0;
            halted          = 1'b0;
            mss_seen_r      = 1'b0;
            peer_mss_r      = 16'd0;
            scale_seen_r    = 1'b0;
            peer_shift_r    = 8'd0;
            sack_seen_r     = 1'b0;
            own_mss         = LOCAL_MSS_RESET;
            own_shift       = {4'd0, LOCAL_SHIFT_RESET};
            mismatches      = 0;
            results_checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[2]))
                    REG_LOCAL_MSS:
                        own_mss = pwdata[15:0];
                    REG_LOCAL_SHIFT:
                    begin
                        if (!scale_seen_r)
                            own_shift = {4'd0, pwdata[3:0]};
                    end
                endcase
            end

            if (out_valid && !out_stall)
            begin
                seen.kind            = res_kind_t'(result_kind);
                seen.data            = out_byte;
                seen.last            = out_last;
                seen.peer.mss_seen   = peer_mss_seen;
                seen.peer.mss        = peer_mss;
                seen.peer.scale_seen = peer_scale_seen;
                seen.peer.shift      = peer_shift;
                seen.peer.sack_seen  = peer_sack_seen;
                seen.rsize           = reply_size;
                results_checked++;
                if (awaited_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: unexpected result %s", $realtime, show(seen));
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t: result %0d mismatch\n  expected %s\n  actual   %s",
                                     $realtime, results_checked, show(want), show(seen));
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (!action)
                    take_option_byte(opt_byte, bytes_left);
                else
                    predict_reply_options(syn_flag, ack_flag);
            end
        end
        awaited = awaited_q.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for tcp_option_parse_build: option regions, build
// requests and register settings, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb;
    import tcpopt_pkg::*;

    localparam int   CLK_PERIOD     = 8;
    localparam int   RESET_CYCLES   = 9;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   DRAIN_CYCLES   = 12;
    localparam int   PHASE_ITEMS    = 47;
    localparam logic ACT_PARSE      = 1'b0;
    localparam logic ACT_BUILD      = 1'b1;

    logic                    clk = 1'b0;
    logic                    rst_n;

    logic                    in_valid;
    logic                    in_stall;
    logic                    action;
    logic [7:0]              opt_byte;
    logic [BYTES_LEFT_W-1:0] bytes_left;
    logic                    syn_flag;
    logic                    ack_flag;

    logic                    out_valid;
    logic                    out_stall;
    logic                    result_kind;
    logic [7:0]              out_byte;
    logic                    out_last;
    logic                    peer_mss_seen;
    logic [15:0]             peer_mss;
    logic                    peer_scale_seen;
    logic [7:0]              peer_shift;
    logic                    peer_sack_seen;
    logic [3:0]              reply_size;

    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    int                      mismatches;
    int                      awaited;
    int                      results_checked;

    int                      requests_sent;
    int                      parse_sent;
    int                      builds_sent;
    int                      calm_cycles;
    int                      stall_left;
    int                      quiet_cycles;

    // Option bytes of the region being sent, first byte at the front
    logic [7:0]              region_bytes[$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    tcp_option_parse_build i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .opt_byte        (opt_byte),
        .bytes_left      (bytes_left),
        .syn_flag        (syn_flag),
        .ack_flag        (ack_flag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .peer_mss_seen   (peer_mss_seen),
        .peer_mss        (peer_mss),
        .peer_scale_seen (peer_scale_seen),
        .peer_shift      (peer_shift),
        .peer_sack_seen  (peer_sack_seen),
        .reply_size      (reply_size),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    tcp_option_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .opt_byte        (opt_byte),
        .bytes_left      (bytes_left),
        .syn_flag        (syn_flag),
        .ack_flag        (ack_flag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .peer_mss_seen   (peer_mss_seen),
        .peer_mss        (peer_mss),
        .peer_scale_seen (peer_scale_seen),
        .peer_shift      (peer_shift),
        .peer_sack_seen  (peer_sack_seen),
        .reply_size      (reply_size),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked)
    );

    // Idle length for either side: mostly none or short, now and then long.
    // Inside a calm stretch nobody idles, so back-to-back traffic is seen too.
    function automatic int gap_cycles();
        int r;
        if (calm_cycles > 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result-side backpressure and the calm stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_left  = 0;
            calm_cycles = 0;
        end
        else
        begin
            if (calm_cycles > 0)
                calm_cycles--;
            else if ($urandom_range(0, 199) == 0)
                calm_cycles = $urandom_range(30, 120);

            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = gap_cycles();
                out_stall  <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: give up when no request, result or register access has moved
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles, %0d results awaited",
                     quiet_cycles, awaited);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drive one request and hold it until the block takes it. Entered and left
    // on a rising edge; in_stall is looked at on the falling edge, where it
    // already reflects the edge that follows.
    task automatic send_request(input logic act, input logic [7:0] b,
                                input logic [BYTES_LEFT_W-1:0] left,
                                input logic syn, input logic ack);
        int gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        opt_byte   <= b;
        bytes_left <= left;
        syn_flag   <= syn;
        ack_flag   <= ack;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        requests_sent++;
        if (act == ACT_BUILD)
            builds_sent++;
        else
            parse_sent++;
    endtask

    // Build request; byte and count are don't-care, so fill them with noise
    task automatic send_build(input logic syn, input logic ack);
        send_request(ACT_BUILD, 8'($urandom), 6'($urandom), syn, ack);
    endtask

    // Send region_bytes with the count of bytes left on each. Unless exact,
    // sometimes overstate the count on the kind byte to hit saturation, end
    // the region with a zero count, or slip a build request in mid-region.
    task automatic send_region(input bit exact);
        int                      total;
        logic [BYTES_LEFT_W-1:0] left;
        total = region_bytes.size();
        for (int k = 0; k < total; k++)
        begin
            left = 6'(total - k);
            if (!exact)
            begin
                if (k == 0 && total > 1 && $urandom_range(0, 9) == 0)
                    left = 6'($urandom_range(MAX_OPTION_BYTES + 1, 63));
                if (left == 6'd1 && $urandom_range(0, 3) == 0)
                    left = 6'd0;
                if ($urandom_range(0, 39) == 0)
                    send_build($urandom_range(0, 4) != 0, 1'($urandom));
            end
            send_request(ACT_PARSE, region_bytes[k], left, 1'($urandom), 1'($urandom));
        end
    endtask

    // Compose an option region: mostly well-formed options with random
    // content, sprinkled with broken ones; now and then pure noise. Options
    // that overhang the end are cut off with the region.
    task automatic compose_region();
        int         span;
        int         room;
        logic [7:0] len;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_OPTION_BYTES)
                                            : $urandom_range(1, 12);
        region_bytes.delete();
        if ($urandom_range(0, 7) == 0)
        begin
            repeat (span) region_bytes.push_back(8'($urandom));
            return;
        end
        while (region_bytes.size() < span)
        begin
            room = span - region_bytes.size();
            case ($urandom_range(0, 15))
                0, 1:
                    region_bytes.push_back(KIND_NOP);
                2, 3, 4, 14:
                begin
                    region_bytes.push_back(KIND_MSS);
                    region_bytes.push_back(LEN_MSS);
                    region_bytes.push_back(8'($urandom));
                    region_bytes.push_back(8'($urandom));
                end
                5, 6:
                begin
                    region_bytes.push_back(KIND_WSCALE);
                    region_bytes.push_back(LEN_WSCALE);
                    region_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                           8'($urandom) : 8'($urandom_range(0, 14)));
                end
                7, 15:
                begin
                    region_bytes.push_back(KIND_SACK_OK);
                    region_bytes.push_back(LEN_SACK_OK);
                end
                8, 9:
                begin
                    // unknown kind, skipped by its length
                    len = 8'($urandom_range(LEN_MIN, 6));
                    region_bytes.push_back(8'($urandom_range(KIND_SACK_OK + 1, 255)));
                    region_bytes.push_back(len);
                    repeat (len - LEN_MIN) region_bytes.push_back(8'($urandom));
                end
                10:
                begin
                    // EOL, then trailing bytes that must be ignored
                    region_bytes.push_back(KIND_EOL);
                    repeat ($urandom_range(0, 3)) region_bytes.push_back(8'($urandom));
                end
                11:
                begin
                    // known kind with a random, usually wrong, length
                    region_bytes.push_back(8'($urandom_range(KIND_MSS, KIND_SACK_OK)));
                    region_bytes.push_back(8'($urandom_range(0, 8)));
                    region_bytes.push_back(8'($urandom));
                end
                12:
                begin
                    // length runs past the end of the region
                    region_bytes.push_back(8'($urandom_range(KIND_MSS, 255)));
                    region_bytes.push_back(8'(room + $urandom_range(1, 5)));
                end
                default:
                begin
                    // unknown kind with length 0 or 1 stops the parse
                    region_bytes.push_back(8'($urandom_range(KIND_SACK_OK + 1, 255)));
                    region_bytes.push_back(8'($urandom_range(0, 1)));
                end
            endcase
        end
        while (region_bytes.size() > span)
            void'(region_bytes.pop_back());
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait until every predicted result is out, then wait out
    // DRAIN_CYCLES so that the block is surely idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        action        <= ACT_PARSE;
        opt_byte      <= 8'd0;
        bytes_left    <= 6'd1;
        syn_flag      <= 1'b0;
        ack_flag      <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= 32'd0;
        requests_sent = 0;
        parse_sent    = 0;
        builds_sent   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Builds at the register extremes before any peer option is seen:
        // SYN alone offers both options, SYN+ACK and no SYN offer nothing
        write_reg(REG_LOCAL_MSS, 32'h0000_FFFF);
        write_reg(REG_LOCAL_SHIFT, 32'd14);
        send_build(1'b1, 1'b0);
        send_build(1'b1, 1'b1);
        send_build(1'b0, 1'b0);
        send_build(1'b0, 1'b1);
        settle();
        write_reg(REG_LOCAL_MSS, 32'd0);
        write_reg(REG_LOCAL_SHIFT, 32'd0);
        send_build(1'b1, 1'b0);

        // One region with every known option, a skipped unknown one, EOL
        // and a trailing byte that the stopped parser must ignore
        region_bytes = '{KIND_MSS, LEN_MSS, 8'h12, 8'h34,
                         KIND_WSCALE, LEN_WSCALE, 8'hFF,
                         KIND_SACK_OK, LEN_SACK_OK, KIND_NOP,
                         8'hC9, 8'd3, 8'hAA, KIND_EOL, 8'h55};
        send_region(1'b1);
        // SYN+ACK now answers with both options and the peer's default shift
        send_build(1'b1, 1'b1);
        // Kind byte as the last byte, with a zero count
        send_request(ACT_PARSE, KIND_MSS, 6'd0, 1'b0, 1'b0);
        // Oversized count saturates; unknown kind with length 1 stops
        send_request(ACT_PARSE, 8'h80, 6'd63, 1'b1, 1'b1);
        send_request(ACT_PARSE, 8'h01, 6'd1, 1'b1, 1'b0);

        // Random regions and builds under four register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(REG_LOCAL_MSS, 32'($urandom_range(0, 65535)));
                    write_reg(REG_LOCAL_SHIFT, 32'($urandom_range(0, 14)));
                end
                1:
                begin
                    write_reg(REG_LOCAL_MSS, 32'd0);
                    write_reg(REG_LOCAL_SHIFT, 32'd14);
                end
                2:
                begin
                    write_reg(REG_LOCAL_MSS, 32'h0000_FFFF);
                    write_reg(REG_LOCAL_SHIFT, 32'd0);
                end
                default:
                begin
                    write_reg(REG_LOCAL_MSS, 32'(LOCAL_MSS_RESET));
                    write_reg(REG_LOCAL_SHIFT, 32'($urandom_range(0, 14)));
                end
            endcase
            while (requests_sent < 24 + PHASE_ITEMS * (ph + 1))
            begin
                compose_region();
                send_region(1'b0);
                if ($urandom_range(0, 2) == 0)
                    send_build($urandom_range(0, 4) != 0, 1'($urandom));
            end
        end

        settle();
        $display("Covered %0d option bytes in framed, broken and noisy regions and %0d build",
                 parse_sent, builds_sent);
        $display("requests over six register settings; %0d results compared, %0d left over.",
                 results_checked, awaited);
        if (mismatches == 0 && awaited == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
